// ===== rtl/ueru_pkg.sv =====
// package for the ultrasonic echo ranger
// types, register indexes and constants shared by all rtl files; no dependencies
package ueru_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] IDX_PRE_DELAY = 3'd0;
  localparam logic [CfgIdxW-1:0] IDX_TRIGGER   = 3'd1;
  localparam logic [CfgIdxW-1:0] IDX_PRESCALE  = 3'd2;
  localparam logic [CfgIdxW-1:0] IDX_TIMEOUT   = 3'd3;

  // register reset values
  localparam logic [15:0] PRE_DELAY_RST = 16'd160;
  localparam logic [15:0] TRIGGER_RST   = 16'd160;
  localparam logic [10:0] PRESCALE_RST  = 11'd256;
  localparam logic [14:0] TIMEOUT_RST   = 15'd1500;

  // prescale clamp bounds
  localparam logic [10:0] PRESCALE_MIN = 11'd1;
  localparam logic [10:0] PRESCALE_MAX = 11'd1024;

  // 343/125 = 2 + 93/125: integer step and fractional step per count
  localparam logic [6:0] DIST_DIV   = 7'd125;
  localparam logic [6:0] DIST_FRAC  = 7'd93;
  localparam int unsigned DistW     = 17;
  localparam logic [15:0] DIST_SAT  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_TRIG = 3'd2,
    PH_WAIT = 3'd3,
    PH_MEAS = 3'd4
  } phase_e;

  // effective configuration
  typedef struct packed {
    logic [15:0] pre_delay_ticks;
    logic [15:0] trigger_ticks;
    logic [10:0] prescale_ticks;  // already clamped to 1..1024
    logic [14:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic command;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        result_valid;
    logic [15:0] distance_mm;
    logic        timed_out;
  } out_t;

  // distance accumulator control
  typedef struct packed {
    logic clear;
    logic incr;
  } dist_ctl_t;

endpackage

// ===== rtl/ueru_cfg.sv =====
// configuration registers of the echo ranger, with prescale clamping
// depends on ueru_pkg
module ueru_cfg import ueru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [15:0] pre_q;
  logic [15:0] trig_q;
  logic [10:0] ps_q;
  logic [14:0] tmo_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= PRE_DELAY_RST;
      trig_q <= TRIGGER_RST;
      ps_q   <= PRESCALE_RST;
      tmo_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        IDX_PRE_DELAY: pre_q  <= cfg_data_i;
        IDX_TRIGGER:   trig_q <= cfg_data_i;
        IDX_PRESCALE:  ps_q   <= cfg_data_i[10:0];
        IDX_TIMEOUT:   tmo_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // clamp prescale into 1..1024
  always_comb begin
    cfg_o.pre_delay_ticks = pre_q;
    cfg_o.trigger_ticks   = trig_q;
    cfg_o.timeout_limit   = tmo_q;
    priority if (ps_q == '0) begin
      cfg_o.prescale_ticks = PRESCALE_MIN;
    end else if (ps_q > PRESCALE_MAX) begin
      cfg_o.prescale_ticks = PRESCALE_MAX;
    end else begin
      cfg_o.prescale_ticks = ps_q;
    end
  end

endmodule

// ===== rtl/ueru_dist.sv =====
// running distance in mm kept alongside the echo count
// adds 2 + 93/125 per count, so no multiply or divide is needed; depends on ueru_pkg
module ueru_dist import ueru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dist_ctl_t   ctl_i,
  output logic [15:0] dist_o
);

  logic [DistW-1:0] dist_q, dist_d;
  logic [6:0]       rem_q, rem_d;
  logic [7:0]       rem_sum;

  // fractional step with carry into the integer part
  always_comb begin
    rem_sum = {1'b0, rem_q} + {1'b0, DIST_FRAC};
    dist_d  = dist_q;
    rem_d   = rem_q;
    if (ctl_i.clear) begin
      dist_d = '0;
      rem_d  = '0;
    end else if (ctl_i.incr) begin
      if (rem_sum >= {1'b0, DIST_DIV}) begin
        rem_d  = 7'(rem_sum - {1'b0, DIST_DIV});
        dist_d = dist_q + DistW'(3);
      end else begin
        rem_d  = rem_sum[6:0];
        dist_d = dist_q + DistW'(2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      rem_q  <= '0;
    end else begin
      dist_q <= dist_d;
      rem_q  <= rem_d;
    end
  end

  // saturate to 16 bits
  assign dist_o = (dist_q[DistW-1]) ? DIST_SAT : dist_q[15:0];

endmodule

// ===== rtl/ueru_core.sv =====
// measurement sequencer: phase machine, delay, prescale and echo counters
// depends on ueru_pkg and ueru_dist
module ueru_core import ueru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] dly_q, dly_d;
  logic [9:0]  ps_q, ps_d;
  logic [14:0] cnt_q, cnt_d;
  logic [15:0] dly_inc;
  logic [10:0] ps_nx;
  logic        done, tmo;
  dist_ctl_t   dctl;
  logic [15:0] dist_mm;

  // state registers, advance once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dly_q   <= '0;
      ps_q    <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dly_q   <= dly_d;
      ps_q    <= ps_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and result of this tick
  always_comb begin
    phase_d    = phase_q;
    dly_d      = dly_q;
    ps_d       = ps_q;
    cnt_d      = cnt_q;
    done       = 1'b0;
    tmo        = 1'b0;
    dctl.clear = 1'b0;
    dctl.incr  = 1'b0;
    dly_inc    = dly_q + 16'd1;
    ps_nx      = {1'b0, ps_q} + 11'd1;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.command) begin
          dly_d   = '0;
          phase_d = (cfg_i.pre_delay_ticks == '0) ? PH_TRIG : PH_PRE;
        end
      end
      PH_PRE: begin
        if (dly_inc >= cfg_i.pre_delay_ticks) begin
          dly_d   = '0;
          phase_d = PH_TRIG;
        end else begin
          dly_d = dly_inc;
        end
      end
      PH_TRIG: begin
        if (dly_inc >= cfg_i.trigger_ticks) begin
          dly_d   = '0;
          phase_d = PH_WAIT;
        end else begin
          dly_d = dly_inc;
        end
      end
      PH_WAIT: begin
        // no timeout while waiting for echo to rise
        if (in_i.echo_level) begin
          cnt_d      = '0;
          ps_d       = '0;
          dctl.clear = 1'b1;
          phase_d    = PH_MEAS;
        end
      end
      PH_MEAS: begin
        // echo falling wins over the limit
        if (!in_i.echo_level) begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end else if (cnt_q >= cfg_i.timeout_limit) begin
          done    = 1'b1;
          tmo     = 1'b1;
          phase_d = PH_IDLE;
        end else if (ps_nx >= cfg_i.prescale_ticks) begin
          ps_d      = '0;
          cnt_d     = cnt_q + 15'd1;
          dctl.incr = 1'b1;
        end else begin
          ps_d = ps_nx[9:0];
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  ueru_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{clear: dctl.clear & step_i, incr: dctl.incr & step_i}),
    .dist_o (dist_mm)
  );

  // outputs reflect the state after this tick
  always_comb begin
    res_o.trigger_level = (phase_d == PH_TRIG);
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.result_valid  = done;
    res_o.distance_mm   = done ? dist_mm : 16'd0;
    res_o.timed_out     = tmo;
  end

endmodule

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
// ultrasonic echo ranger, top level: input register, sequencer, result register
// path: a request accepted into the input register steps the sequencer, and the result register captures its result
// throughput: one request per cycle; the whole pipeline stalls only while
//   the result register is full and not taken
// reset: asynchronous active low; config registers return to defaults, valid flags clear, phase idle
// depends on ueru_pkg, ueru_cfg, ueru_core, ueru_dist
module ultrasonic_echo_ranger_unit import ueru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic  adv;
  logic  s1_valid_q;
  in_t   s1_q;
  logic  out_valid_q;
  out_t  out_q;
  out_t  res;
  cfg_t  cfg;

  // pipeline moves when the result register is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  ueru_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  ueru_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv && s1_valid_q),
    .in_i   (s1_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished measurement leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_valid |-> !out_q.busy_res && !out_q.trigger_level)
    else $error("result reported while still busy");

  // timed-out flag only comes with a result
  a_tmo_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.timed_out |-> out_q.result_valid)
    else $error("timed_out without result_valid");

  // trigger only driven during a measurement
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.trigger_level |-> out_q.busy_res)
    else $error("trigger high while idle");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled with free result register");

endmodule

// ===== tb/ranger_sb_pkg.sv =====
// scoreboard for the ultrasonic echo ranger testbench
// holds a tick-accurate copy of the ranging sequencer and its registers; depends on ueru_pkg
package ranger_sb_pkg;
  import ueru_pkg::*;

  // speed of sound scaling: mm = count * 343 / 125
  localparam int unsigned SOUND_MUL  = 343;
  localparam int unsigned SOUND_DIV  = 125;
  localparam int unsigned REPORT_MAX = 10;

  class ranger_scoreboard;
    // register copies
    logic [15:0] pre_delay;
    logic [15:0] trig_len;
    logic [10:0] presc;
    logic [14:0] limit;
    // sequencer copy
    phase_e      ph;
    logic [15:0] delay_cnt;
    logic [9:0]  presc_cnt;
    logic [14:0] echo_cnt;
    // one expected reading per accepted tick
    out_t        expected_readings[$];
    int unsigned n_req;
    int unsigned n_res;
    int unsigned n_meas;
    int unsigned n_tmo;
    int unsigned n_err;

    function new();
      pre_delay = PRE_DELAY_RST;
      trig_len  = TRIGGER_RST;
      presc     = PRESCALE_RST;
      limit     = TIMEOUT_RST;
      ph        = PH_IDLE;
      delay_cnt = '0;
      presc_cnt = '0;
      echo_cnt  = '0;
      n_req     = 0;
      n_res     = 0;
      n_meas    = 0;
      n_tmo     = 0;
      n_err     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        IDX_PRE_DELAY: pre_delay = val;
        IDX_TRIGGER:   trig_len  = val;
        IDX_PRESCALE:  presc     = val[10:0];
        IDX_TIMEOUT:   limit     = val[14:0];
        default: ;
      endcase
    endfunction

    // prescale after clamping into 1..1024
    function int unsigned eff_prescale();
      if (presc < PRESCALE_MIN) return 32'(PRESCALE_MIN);
      if (presc > PRESCALE_MAX) return 32'(PRESCALE_MAX);
      return 32'(presc);
    endfunction

    // high ticks inside the measuring phase until the count reaches the limit
    function int unsigned ticks_to_limit();
      return limit * eff_prescale();
    endfunction

    function logic [15:0] range_mm(logic [14:0] cnt);
      int unsigned mm;
      mm = cnt * SOUND_MUL / SOUND_DIV;
      return (mm > DIST_SAT) ? DIST_SAT : mm[15:0];
    endfunction

    function string fmt(out_t r);
      return $sformatf("trig %0b busy %0b valid %0b dist %0d tmo %0b", r.trigger_level,
                       r.busy_res, r.result_valid, r.distance_mm, r.timed_out);
    endfunction

    function void report(string msg);
      n_err++;
      if (n_err <= REPORT_MAX) $display("error: %s", msg);
    endfunction

    // advance the sequencer copy by one tick and queue the reading it gives
    function void note_request(in_t req);
      out_t        want;
      logic [10:0] nxt;
      want = '0;
      n_req++;
      case (ph)
        PH_IDLE: begin
          if (req.command) begin
            delay_cnt = '0;
            ph = (pre_delay == '0) ? PH_TRIG : PH_PRE;
          end
        end
        PH_PRE: begin
          delay_cnt++;
          if (delay_cnt >= pre_delay) begin
            delay_cnt = '0;
            ph = PH_TRIG;
          end
        end
        PH_TRIG: begin
          delay_cnt++;
          if (delay_cnt >= trig_len) begin
            delay_cnt = '0;
            ph = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (req.echo_level) begin
            echo_cnt  = '0;
            presc_cnt = '0;
            ph = PH_MEAS;
          end
        end
        PH_MEAS: begin
          // echo falling wins over the limit on the same tick
          if (!req.echo_level || echo_cnt >= limit) begin
            want.result_valid = 1'b1;
            want.timed_out    = req.echo_level;
            want.distance_mm  = range_mm(echo_cnt);
            ph = PH_IDLE;
          end else begin
            nxt = {1'b0, presc_cnt} + 11'd1;
            if (nxt >= eff_prescale()) begin
              presc_cnt = '0;
              echo_cnt++;
            end else begin
              presc_cnt = nxt[9:0];
            end
          end
        end
        default: ph = PH_IDLE;
      endcase
      want.trigger_level = (ph == PH_TRIG);
      want.busy_res      = (ph != PH_IDLE);
      if (want.result_valid) begin
        n_meas++;
        if (want.timed_out) n_tmo++;
      end
      expected_readings.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      n_res++;
      if (expected_readings.size() == 0) begin
        report($sformatf("reading with no request pending: %s", fmt(got)));
        return;
      end
      want = expected_readings.pop_front();
      if (got.trigger_level !== want.trigger_level || got.busy_res !== want.busy_res ||
          got.result_valid !== want.result_valid || got.distance_mm !== want.distance_mm ||
          got.timed_out !== want.timed_out)
        report($sformatf("reading %0d: expected %s, got %s", n_res, fmt(want), fmt(got)));
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench for ultrasonic_echo_ranger_unit: directed corner settings, then random ranging runs
// drives ticks and register writes, checks every reading against ranger_sb_pkg; depends on ueru_pkg
module testbench;
  import ueru_pkg::*;
  import ranger_sb_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 4;
  localparam int unsigned END_CYCLES  = 8;
  localparam int unsigned N_ITEMS     = 900;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_COMB,
    RX_BURSTY
  } rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_t                 in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  out_t                out_data_o;

  ranger_scoreboard sb = new();

  int unsigned burst_left  = 0;
  int unsigned n_sent      = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned rx_span     = 0;
  int unsigned rx_hold     = 0;
  int unsigned rx_phase    = 0;

  ultrasonic_echo_ranger_unit uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // reading side: stall pattern is redrawn from four modes whenever its random span runs out
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_COMB:   out_ready_i <= (rx_phase % 5 != 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // one tick request, sent in bursts with random gaps
  task automatic send_tick(input logic cmd, input logic echo);
    in_t         req;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
    end
    burst_left--;
    req.command    = cmd;
    req.echo_level = echo;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // stop sending and wait for every pending reading
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(input logic [CfgDataW-1:0] pre, input logic [CfgDataW-1:0] trig,
                               input logic [CfgDataW-1:0] ps, input logic [CfgDataW-1:0] lim);
    drain_readings();
    write_reg(IDX_PRE_DELAY, pre);
    write_reg(IDX_TRIGGER, trig);
    write_reg(IDX_PRESCALE, ps);
    write_reg(IDX_TIMEOUT, lim);
    cfg_we_i <= 1'b0;
  endtask

  // indexes past the last register must change nothing
  task automatic poke_unused_regs();
    drain_readings();
    for (int i = int'(IDX_TIMEOUT) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // start, ride out pre-delay and trigger, hold echo low then high, drop echo
  task automatic run_ranging(input int unsigned wait_len, input int unsigned high_len,
                             input bit pause_mid);
    int unsigned busy;
    busy = int'(sb.pre_delay) + ((sb.trig_len == '0) ? 1 : int'(sb.trig_len));
    send_tick(1'b1, 1'($urandom));
    // starts while busy should be ignored
    repeat (busy) send_tick(1'($urandom), 1'($urandom));
    repeat (wait_len) send_tick(1'($urandom), 1'b0);
    for (int unsigned i = 0; i < high_len; i++) begin
      if (pause_mid && i == high_len / 2) drain_readings();
      send_tick(1'b0, 1'b1);
    end
    send_tick(1'b0, 1'b0);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_tick($urandom_range(0, 3) == 0, 1'($urandom));
  endtask

  initial begin
    int unsigned span;
    int unsigned high_len;
    int unsigned pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one full prescaled count, then echo drops
    run_ranging(3, 2 + sb.eff_prescale(), 1'b0);

    // zero everywhere: one-tick trigger, prescale 1, limit zero
    load_settings(16'd0, 16'd0, 16'd0, 16'd0);
    run_ranging(2, 3, 1'b0);
    run_ranging(0, 1, 1'b0);
    poke_unused_regs();
    run_ranging(1, 2, 1'b0);

    // random settings, mostly well-formed ranging runs with some noise
    while (n_sent < N_ITEMS) begin
      load_settings(CfgDataW'($urandom_range(0, 6)), CfgDataW'($urandom_range(0, 6)),
                    CfgDataW'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 16)
                                                         : $urandom_range(0, 4)),
                    CfgDataW'($urandom_range(0, 12)));
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          span = sb.ticks_to_limit();
          case ($urandom_range(0, 3))
            0:       high_len = span + 1;
            1:       high_len = span + 2;
            default: high_len = $urandom_range(1, span + 3);
          endcase
          run_ranging($urandom_range(0, 8), high_len, pick == 0);
        end else begin
          send_noise($urandom_range(5, 40));
        end
      end
      repeat ($urandom_range(0, 5)) send_tick(1'b0, 1'($urandom));
    end

    drain_readings();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("sent %0d tick requests, checked %0d readings", sb.n_req, sb.n_res);
    $display("%0d ranging results, %0d of them timed out, %0d errors",
             sb.n_meas, sb.n_tmo, sb.n_err);
    if (sb.n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== ultrasonic_echo_ranger_unit.f =====
rtl/ueru_pkg.sv
rtl/ueru_cfg.sv
rtl/ueru_dist.sv
rtl/ueru_core.sv
rtl/ultrasonic_echo_ranger_unit.sv
tb/ranger_sb_pkg.sv
tb/testbench.sv
